[sv/jhsd_pkg.sv]
package jhsd_pkg;

  localparam int MAX_CODE_LENGTH_DEF = 16;
  localparam int SYMBOL_DEPTH_DEF    = 256;
  localparam int NUM_LENGTHS         = 16;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_00   = 8'h00;
  localparam logic [7:0] RST_FIRST = 8'hD0;
  localparam logic [7:0] RST_LAST  = 8'hD7;

  typedef enum logic [1:0] {
    CMD_TABLE   = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_SYMBOL = 3'd0,
    KIND_HALT   = 3'd1,
    KIND_BAD    = 3'd2,
    KIND_READY  = 3'd3,
    KIND_RST    = 3'd4,
    KIND_MISUSE = 3'd5
  } kind_e;

  typedef enum logic {
    OP_EMIT   = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_BITS,
    BK_SYMRD,
    BK_FLUSH,
    BK_READY
  } bk_state_e;

  // One job from the front to the back.
  typedef struct packed {
    op_e        op;
    logic       clr;        // clear the bit state first
    logic       has_res;    // emit kind/value
    kind_e      kind;
    logic [7:0] value;      // result value, or the byte to decode
    logic       add_ready;  // follow with a table-ready result
  } job_t;

endpackage

[sv/jhsd_ram.sv]
module jhsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/jhsd_queue.sv]
module jhsd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jhsd_pkg::job_t  push_job_i,
  input  logic            pop_i,
  output jhsd_pkg::job_t  head_job_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int Depth = jhsd_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  jhsd_pkg::job_t  slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign head_job_o = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

endmodule

[sv/jhsd_front.sv]
module jhsd_front #(
  parameter int MAX_CODE_LENGTH = jhsd_pkg::MAX_CODE_LENGTH_DEF,
  parameter int SYMBOL_DEPTH    = jhsd_pkg::SYMBOL_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      command_i,
  input  logic [7:0]                      byte_value_i,
  input  logic                            drained_i,
  input  logic                            queue_full_i,
  output logic                            push_o,
  output jhsd_pkg::job_t                  job_o,
  output logic                            ram_we_o,
  output logic [$clog2(SYMBOL_DEPTH)-1:0] ram_waddr_o,
  output logic [7:0]                      ram_wdata_o,
  output logic [jhsd_pkg::NUM_LENGTHS-1:0][7:0]  len_count_o,
  output logic [jhsd_pkg::NUM_LENGTHS-1:0][15:0] first_code_o,
  output logic [jhsd_pkg::NUM_LENGTHS-1:0][$clog2(SYMBOL_DEPTH+1)-1:0] sym_base_o
);

  localparam int NumLen  = jhsd_pkg::NUM_LENGTHS;
  localparam int AddrW   = $clog2(SYMBOL_DEPTH);
  localparam int SymCntW = $clog2(SYMBOL_DEPTH + 1);
  localparam int LpW     = $clog2(NumLen + SYMBOL_DEPTH + 1);

  logic [LpW-1:0]     lp_q, lp_d;
  logic [SymCntW-1:0] total_q, total_d;
  logic [16:0]        next_code_q, next_code_d;
  logic               pending_ff_q, pending_ff_d;
  logic               halted_q, halted_d;

  logic [NumLen-1:0][7:0]         len_count_q;
  logic [NumLen-1:0][15:0]        first_code_q;
  logic [NumLen-1:0][SymCntW-1:0] sym_base_q;

  logic               accept;
  logic               tbl_done, in_counts;
  logic [LpW-1:0]     sym_end;
  logic [4:0]         len;
  logic [17:0]        first_x, avail, room, cnt_a, cnt_b, next_x;
  logic               over_a, over_b;
  logic [SymCntW-1:0] new_total;
  logic               cnt_we;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !queue_full_i && (command_i != jhsd_pkg::CMD_TABLE || drained_i);

  assign sym_end   = LpW'(NumLen) + LpW'(total_q);
  assign tbl_done  = (lp_q == sym_end);
  assign in_counts = (lp_q < LpW'(NumLen));

  // Canonical code for the length now being counted.
  always_comb begin
    len       = {1'b0, lp_q[3:0]} + 5'd1;
    first_x   = {next_code_q, 1'b0};
    avail     = (len > 5'(MAX_CODE_LENGTH)) ? '0 : ((18'd1 << len) - first_x);
    room      = 18'(SYMBOL_DEPTH) - 18'(total_q);
    over_a    = (18'(byte_value_i) > avail);
    cnt_a     = over_a ? avail : 18'(byte_value_i);
    over_b    = (cnt_a > room);
    cnt_b     = over_b ? room : cnt_a;
    next_x    = first_x + cnt_b;
    new_total = total_q + SymCntW'(cnt_b);
  end

  always_comb begin
    lp_d         = lp_q;
    total_d      = total_q;
    next_code_d  = next_code_q;
    pending_ff_d = pending_ff_q;
    halted_d     = halted_q;
    push_o       = 1'b0;
    job_o        = '{op: jhsd_pkg::OP_EMIT, clr: 1'b0, has_res: 1'b1,
                     kind: jhsd_pkg::KIND_MISUSE, value: '0, add_ready: 1'b0};
    ram_we_o     = 1'b0;
    ram_waddr_o  = AddrW'(lp_q - LpW'(NumLen));
    ram_wdata_o  = byte_value_i;
    cnt_we       = 1'b0;

    if (accept) begin
      case (command_i)
        jhsd_pkg::CMD_TABLE: begin
          if (in_counts) begin
            cnt_we      = 1'b1;
            lp_d        = lp_q + 1'b1;
            total_d     = new_total;
            next_code_d = next_x[16:0];
            if (over_a || over_b) begin
              push_o          = 1'b1;
              job_o.add_ready = (lp_q == LpW'(NumLen - 1)) && (new_total == '0);
            end else if ((lp_q == LpW'(NumLen - 1)) && (new_total == '0)) begin
              push_o     = 1'b1;
              job_o.kind = jhsd_pkg::KIND_READY;
            end
          end else if (!tbl_done) begin
            ram_we_o = 1'b1;
            lp_d     = lp_q + 1'b1;
            if (lp_q + 1'b1 == sym_end) begin
              push_o     = 1'b1;
              job_o.kind = jhsd_pkg::KIND_READY;
            end
          end else begin
            push_o = 1'b1;
          end
        end
        jhsd_pkg::CMD_DATA: begin
          if (in_counts || !tbl_done) begin
            push_o = 1'b1;
          end else if (halted_q) begin
            // drop: decoding halted until restart
          end else if (pending_ff_q) begin
            if (byte_value_i == jhsd_pkg::BYTE_00) begin
              pending_ff_d = 1'b0;
              push_o       = 1'b1;
              job_o.op     = jhsd_pkg::OP_DECODE;
              job_o.value  = jhsd_pkg::BYTE_FF;
            end else if (byte_value_i == jhsd_pkg::BYTE_FF) begin
              // fill byte: keep waiting for the marker code
            end else if (byte_value_i inside {[jhsd_pkg::RST_FIRST:jhsd_pkg::RST_LAST]}) begin
              pending_ff_d = 1'b0;
              push_o       = 1'b1;
              job_o.clr    = 1'b1;
              job_o.kind   = jhsd_pkg::KIND_RST;
              job_o.value  = byte_value_i;
            end else begin
              pending_ff_d = 1'b0;
              halted_d     = 1'b1;
              push_o       = 1'b1;
              job_o.kind   = jhsd_pkg::KIND_HALT;
              job_o.value  = byte_value_i;
            end
          end else if (byte_value_i == jhsd_pkg::BYTE_FF) begin
            pending_ff_d = 1'b1;
          end else begin
            push_o      = 1'b1;
            job_o.op    = jhsd_pkg::OP_DECODE;
            job_o.value = byte_value_i;
          end
        end
        jhsd_pkg::CMD_RESTART: begin
          lp_d          = '0;
          total_d       = '0;
          next_code_d   = '0;
          pending_ff_d  = 1'b0;
          halted_d      = 1'b0;
          push_o        = 1'b1;
          job_o.clr     = 1'b1;
          job_o.has_res = 1'b0;
        end
        default: begin
          push_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q         <= '0;
      total_q      <= '0;
      next_code_q  <= '0;
      pending_ff_q <= 1'b0;
      halted_q     <= 1'b0;
    end else begin
      lp_q         <= lp_d;
      total_q      <= total_d;
      next_code_q  <= next_code_d;
      pending_ff_q <= pending_ff_d;
      halted_q     <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      len_count_q[lp_q[3:0]]  <= cnt_b[7:0];
      first_code_q[lp_q[3:0]] <= first_x[15:0];
      sym_base_q[lp_q[3:0]]   <= total_q;
    end
  end

  assign len_count_o  = len_count_q;
  assign first_code_o = first_code_q;
  assign sym_base_o   = sym_base_q;

endmodule

[sv/jhsd_back.sv]
module jhsd_back #(
  parameter int MAX_CODE_LENGTH = jhsd_pkg::MAX_CODE_LENGTH_DEF,
  parameter int SYMBOL_DEPTH    = jhsd_pkg::SYMBOL_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  input  jhsd_pkg::job_t                  job_i,
  output logic                            job_pop_o,
  output logic                            idle_o,
  input  logic [jhsd_pkg::NUM_LENGTHS-1:0][7:0]  len_count_i,
  input  logic [jhsd_pkg::NUM_LENGTHS-1:0][15:0] first_code_i,
  input  logic [jhsd_pkg::NUM_LENGTHS-1:0][$clog2(SYMBOL_DEPTH+1)-1:0] sym_base_i,
  output logic [$clog2(SYMBOL_DEPTH)-1:0] ram_raddr_o,
  input  logic [7:0]                      ram_rdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output jhsd_pkg::kind_e                 kind_o,
  output logic [7:0]                      value_o,
  output logic [4:0]                      code_length_o,
  output logic                            last_o
);

  localparam int AddrW   = $clog2(SYMBOL_DEPTH);
  localparam int SymCntW = $clog2(SYMBOL_DEPTH + 1);
  localparam int SumW    = ((SymCntW > 8) ? SymCntW : 8) + 1;

  jhsd_pkg::bk_state_e state_q, state_d;

  logic [15:0] acc_q, acc_d;
  logic [4:0]  nbits_q, nbits_d;
  logic [7:0]  sh_q, sh_d;
  logic [3:0]  rem_q, rem_d;

  logic            hold_valid_q, hold_valid_d;
  jhsd_pkg::kind_e hold_kind_q, hold_kind_d;
  logic [7:0]      hold_value_q, hold_value_d;
  logic [4:0]      hold_len_q, hold_len_d;

  logic            out_valid_q;
  jhsd_pkg::kind_e out_kind_q;
  logic [7:0]      out_value_q;
  logic [4:0]      out_len_q;
  logic            out_last_q;

  logic            out_free, out_push, push_last;
  jhsd_pkg::kind_e push_kind;
  logic [7:0]      push_value;
  logic [4:0]      push_len;

  logic [15:0]     acc_n;
  logic [4:0]      nbits_n;
  logic [3:0]      li;
  logic [7:0]      cnt;
  logic [15:0]     first;
  logic [16:0]     diff;
  logic            match, bad;
  logic [SumW-1:0] idx_sum;

  assign out_free = !out_valid_q || out_ready_i;

  // One code bit: compare the grown code against this length's range.
  always_comb begin
    acc_n   = {acc_q[14:0], sh_q[7]};
    nbits_n = nbits_q + 5'd1;
    li      = nbits_q[3:0];
    cnt     = len_count_i[li];
    first   = first_code_i[li];
    diff    = {1'b0, acc_n} - {1'b0, first};
    match   = (cnt != '0) && !diff[16] && (diff[15:8] == '0) && (diff[7:0] < cnt);
    bad     = !match && (nbits_n >= 5'(MAX_CODE_LENGTH));
    idx_sum = SumW'(sym_base_i[li]) + SumW'(diff[7:0]);
  end

  assign ram_raddr_o = idx_sum[AddrW-1:0];

  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    nbits_d      = nbits_q;
    sh_d         = sh_q;
    rem_d        = rem_q;
    hold_valid_d = hold_valid_q;
    hold_kind_d  = hold_kind_q;
    hold_value_d = hold_value_q;
    hold_len_d   = hold_len_q;
    job_pop_o    = 1'b0;
    out_push     = 1'b0;
    push_kind    = hold_kind_q;
    push_value   = hold_value_q;
    push_len     = hold_len_q;
    push_last    = 1'b0;

    case (state_q)
      jhsd_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          if (job_i.op == jhsd_pkg::OP_DECODE) begin
            job_pop_o = 1'b1;
            sh_d      = job_i.value;
            rem_d     = 4'd8;
            state_d   = jhsd_pkg::BK_BITS;
          end else if (!job_i.has_res || out_free) begin
            job_pop_o = 1'b1;
            if (job_i.clr) begin
              acc_d   = '0;
              nbits_d = '0;
            end
            if (job_i.has_res) begin
              out_push   = 1'b1;
              push_kind  = job_i.kind;
              push_value = job_i.value;
              push_len   = '0;
              push_last  = !job_i.add_ready;
              if (job_i.add_ready) begin
                state_d = jhsd_pkg::BK_READY;
              end
            end
          end
        end
      end
      jhsd_pkg::BK_READY: begin
        if (out_free) begin
          out_push   = 1'b1;
          push_kind  = jhsd_pkg::KIND_READY;
          push_value = '0;
          push_len   = '0;
          push_last  = 1'b1;
          state_d    = jhsd_pkg::BK_IDLE;
        end
      end
      jhsd_pkg::BK_BITS: begin
        // Advance only when a held result could be passed on.
        if (!hold_valid_q || out_free) begin
          sh_d  = {sh_q[6:0], 1'b0};
          rem_d = rem_q - 4'd1;
          if (match || bad) begin
            out_push     = hold_valid_q;
            acc_d        = '0;
            nbits_d      = '0;
            hold_valid_d = 1'b1;
            hold_kind_d  = match ? jhsd_pkg::KIND_SYMBOL : jhsd_pkg::KIND_BAD;
            hold_value_d = '0;
            hold_len_d   = match ? nbits_n : 5'd0;
          end else begin
            acc_d   = acc_n;
            nbits_d = nbits_n;
          end
          if (match) begin
            state_d = jhsd_pkg::BK_SYMRD;
          end else if (rem_q == 4'd1) begin
            state_d = jhsd_pkg::BK_FLUSH;
          end
        end
      end
      jhsd_pkg::BK_SYMRD: begin
        hold_value_d = ram_rdata_i;
        state_d      = (rem_q == '0) ? jhsd_pkg::BK_FLUSH : jhsd_pkg::BK_BITS;
      end
      jhsd_pkg::BK_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = jhsd_pkg::BK_IDLE;
        end else if (out_free) begin
          out_push     = 1'b1;
          push_last    = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = jhsd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = jhsd_pkg::BK_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == jhsd_pkg::BK_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= jhsd_pkg::BK_IDLE;
      acc_q        <= '0;
      nbits_q      <= '0;
      rem_q        <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      acc_q        <= acc_d;
      nbits_q      <= nbits_d;
      rem_q        <= rem_d;
      hold_valid_q <= hold_valid_d;
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q         <= sh_d;
    hold_kind_q  <= hold_kind_d;
    hold_value_q <= hold_value_d;
    hold_len_q   <= hold_len_d;
    if (out_push) begin
      out_kind_q  <= push_kind;
      out_value_q <= push_value;
      out_len_q   <= push_len;
      out_last_q  <= push_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign value_o       = out_value_q;
  assign code_length_o = out_len_q;
  assign last_o        = out_last_q;

endmodule

[sv/jpeg_huffman_symbol_decoder.sv]
// Channel | Handshake                 | Fields
// in      | in_valid_i / in_ready_o   | command_i, byte_value_i
// out     | out_valid_o / out_ready_i | kind_o, value_o, code_length_o, last_o
//
// Flow: a table byte waits until the job queue and the bit decoder are empty. The decoder
//   takes a data byte through dispatch, eight bit steps, one symbol RAM read per symbol
//   and a flush; the loop takes one bit per cycle unless a held result is stalled.
// Reset: rst_ni clears control state; code tables and symbol RAM are loaded before use.
// Stalls: the job queue lets the front run ahead while out_ready_i holds the decoder.
module jpeg_huffman_symbol_decoder #(
  parameter int MAX_CODE_LENGTH = jhsd_pkg::MAX_CODE_LENGTH_DEF,
  parameter int SYMBOL_DEPTH    = jhsd_pkg::SYMBOL_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] byte_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] value_o,
  output logic [4:0] code_length_o,
  output logic       last_o
);

  localparam int NumLen  = jhsd_pkg::NUM_LENGTHS;
  localparam int AddrW   = $clog2(SYMBOL_DEPTH);
  localparam int SymCntW = $clog2(SYMBOL_DEPTH + 1);

  // Jobs from the classifier to the bit decoder.
  logic           push, pop, q_full, q_empty, back_idle, drained;
  jhsd_pkg::job_t push_job, head_job;

  // Code tables, written by the front, read by the decoder.
  logic [NumLen-1:0][7:0]         len_count;
  logic [NumLen-1:0][15:0]        first_code;
  logic [NumLen-1:0][SymCntW-1:0] sym_base;

  // Symbol store.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  jhsd_pkg::kind_e  kind;

  // Nothing in flight: safe to rewrite the tables.
  assign drained = q_empty && back_idle;

  jhsd_front #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
    .SYMBOL_DEPTH   (SYMBOL_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .byte_value_i(byte_value_i),
    .drained_i   (drained),
    .queue_full_i(q_full),
    .push_o      (push),
    .job_o       (push_job),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .len_count_o (len_count),
    .first_code_o(first_code),
    .sym_base_o  (sym_base)
  );

  jhsd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .pop_i     (pop),
    .head_job_o(head_job),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  jhsd_ram #(
    .WIDTH(8),
    .DEPTH(SYMBOL_DEPTH)
  ) u_sym_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  jhsd_back #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
    .SYMBOL_DEPTH   (SYMBOL_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!q_empty),
    .job_i        (head_job),
    .job_pop_o    (pop),
    .idle_o       (back_idle),
    .len_count_i  (len_count),
    .first_code_i (first_code),
    .sym_base_i   (sym_base),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind),
    .value_o      (value_o),
    .code_length_o(code_length_o),
    .last_o       (last_o)
  );

  assign kind_o = kind;

endmodule

[sv/jhsd_checker.sv]
module jhsd_checker #(
  parameter int MAX_CODE_LENGTH = jhsd_pkg::MAX_CODE_LENGTH_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] kind_i,
  input logic [7:0] value_i,
  input logic [4:0] code_length_i,
  input logic       last_i
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(value_i)
      && $stable(code_length_i) && $stable(last_i))
    else $error("output result changed while stalled");

  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != 3'(jhsd_pkg::KIND_SYMBOL) |-> code_length_i == '0)
    else $error("non-symbol result with a code length");

  a_sym_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == 3'(jhsd_pkg::KIND_SYMBOL)
      |-> code_length_i != '0 && code_length_i <= 5'(MAX_CODE_LENGTH))
    else $error("symbol code length out of range");

  a_status_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == 3'(jhsd_pkg::KIND_BAD) || kind_i == 3'(jhsd_pkg::KIND_READY)
      || kind_i == 3'(jhsd_pkg::KIND_MISUSE)) |-> value_i == '0)
    else $error("status result carries a value");

  // Restart markers are the only result of their byte.
  a_rst_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == 3'(jhsd_pkg::KIND_RST)
      |-> last_i && value_i[7:3] == jhsd_pkg::RST_FIRST[7:3])
    else $error("malformed restart marker result");

endmodule

bind jpeg_huffman_symbol_decoder jhsd_checker #(
  .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
) u_jhsd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_i       (kind_o),
  .value_i      (value_o),
  .code_length_i(code_length_o),
  .last_i       (last_o)
);

[dv/jpeg_huffman_symbol_decoder_tb.sv]
`timescale 1ns / 100ps

module jpeg_huffman_symbol_decoder_tb;

  localparam int MAX_LEN      = jhsd_pkg::MAX_CODE_LENGTH_DEF;
  localparam int SYM_DEPTH    = jhsd_pkg::SYMBOL_DEPTH_DEF;
  localparam int NUM_LEN      = jhsd_pkg::NUM_LENGTHS;
  localparam int MAX_RESULTS  = 8;
  localparam int CYCLE_LIMIT  = 200000;
  // Jobs that make no result (data bytes that end mid-code, restarts) may still sit in the job
  // queue when the last result is out: four queued plus one in the decoder.
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 400;

  // The command field is two bits wide; the block has no name for the fourth code.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    jhsd_pkg::kind_e kind;
    logic [7:0]      value;
    logic [4:0]      code_len;
    logic            last;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] command_i;
  logic [7:0] byte_value_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] kind_o;
  logic [7:0] value_o;
  logic [4:0] code_length_o;
  logic       last_o;

  jpeg_huffman_symbol_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .byte_value_i  (byte_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .code_length_o (code_length_o),
    .last_o        (last_o)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder state as the testbench tracks it
  // ---------------------------------------------------------------------------
  int         len_count  [NUM_LEN];  // codes per length, after clamping
  int         len_first  [NUM_LEN];  // first canonical code of each length
  int         len_base   [NUM_LEN];  // store index of each length's first symbol
  logic [7:0] sym_mem    [SYM_DEPTH];
  int         load_pos;
  int         sym_total;
  int         next_first;
  int         code_acc;
  int         code_bits;
  bit         ff_seen;
  bit         decode_halted;

  result_t    step_results[$];    // results of the byte being predicted
  result_t    awaited_results[$]; // results still owed by the block, oldest first

  int         tx_idle_pct;
  int         rx_idle_pct;
  int         rx_hold_len;
  logic       rx_held = 1'b0;
  event       rx_hold_ev;

  int         cycles;
  int         mismatches;
  int         transfers_in;
  int         results_out;
  int         kind_hits[8];

  function automatic void reset_decoder_state();
    load_pos      = 0;
    sym_total     = 0;
    next_first    = 0;
    code_acc      = 0;
    code_bits     = 0;
    ff_seen       = 1'b0;
    decode_halted = 1'b0;
  endfunction

  function automatic void emit_result(jhsd_pkg::kind_e k, logic [7:0] v, logic [4:0] l);
    result_t r;
    if (step_results.size() >= MAX_RESULTS) return;
    r.kind       = k;
    r.value      = v;
    r.code_len   = l;
    r.last       = 1'b0;
    step_results = {step_results, r};
  endfunction

  // Shift one byte into the code register MSB first; match after every bit.
  function automatic void decode_bits(logic [7:0] d);
    int li;
    int idx;
    for (int i = 7; i >= 0; i--) begin
      code_acc = ((code_acc << 1) | d[i]) & 'hFFFF;
      code_bits++;
      li = (code_bits - 1) & 15;
      if (len_count[li] != 0 && code_acc >= len_first[li] &&
          code_acc - len_first[li] < len_count[li]) begin
        idx = len_base[li] + (code_acc - len_first[li]);
        emit_result(jhsd_pkg::KIND_SYMBOL, (idx < SYM_DEPTH) ? sym_mem[idx] : 8'h00,
                    5'(code_bits));
        code_acc  = 0;
        code_bits = 0;
      end else if (code_bits >= MAX_LEN) begin
        emit_result(jhsd_pkg::KIND_BAD, 8'h00, 5'd0);
        code_acc  = 0;
        code_bits = 0;
      end
    end
  endfunction

  function automatic void table_byte(logic [7:0] b);
    int len;
    int first;
    int avail;
    int room;
    int cnt;
    bit clamped;
    if (load_pos < NUM_LEN) begin
      // Count byte: clamp to the code space and the store room left.
      len     = load_pos + 1;
      first   = next_first << 1;
      avail   = (len > MAX_LEN) ? 0 : (1 << len) - first;
      room    = SYM_DEPTH - sym_total;
      cnt     = b;
      clamped = 1'b0;
      if (cnt > avail) begin
        cnt     = avail;
        clamped = 1'b1;
      end
      if (cnt > room) begin
        cnt     = room;
        clamped = 1'b1;
      end
      len_count[load_pos] = cnt;
      len_first[load_pos] = first & 'hFFFF;
      len_base[load_pos]  = sym_total;
      next_first = first + cnt;
      sym_total += cnt;
      load_pos++;
      if (clamped) emit_result(jhsd_pkg::KIND_MISUSE, 8'h00, 5'd0);
      if (load_pos == NUM_LEN && sym_total == 0) begin
        emit_result(jhsd_pkg::KIND_READY, 8'h00, 5'd0);
      end
    end else if (load_pos < NUM_LEN + sym_total) begin
      sym_mem[load_pos - NUM_LEN] = b;
      load_pos++;
      if (load_pos == NUM_LEN + sym_total) emit_result(jhsd_pkg::KIND_READY, 8'h00, 5'd0);
    end else begin
      emit_result(jhsd_pkg::KIND_MISUSE, 8'h00, 5'd0);
    end
  endfunction

  function automatic void data_byte(logic [7:0] b);
    if (!(load_pos >= NUM_LEN && load_pos == NUM_LEN + sym_total)) begin
      emit_result(jhsd_pkg::KIND_MISUSE, 8'h00, 5'd0);
    end else if (decode_halted) begin
      // drop data until a restart
    end else if (ff_seen) begin
      if (b == jhsd_pkg::BYTE_00) begin
        ff_seen = 1'b0;
        decode_bits(jhsd_pkg::BYTE_FF);
      end else if (b == jhsd_pkg::BYTE_FF) begin
        // fill byte: keep waiting for the marker code
      end else if (b >= jhsd_pkg::RST_FIRST && b <= jhsd_pkg::RST_LAST) begin
        ff_seen   = 1'b0;
        code_acc  = 0;
        code_bits = 0;
        emit_result(jhsd_pkg::KIND_RST, b, 5'd0);
      end else begin
        ff_seen       = 1'b0;
        decode_halted = 1'b1;
        emit_result(jhsd_pkg::KIND_HALT, b, 5'd0);
      end
    end else if (b == jhsd_pkg::BYTE_FF) begin
      ff_seen = 1'b1;
    end else begin
      decode_bits(b);
    end
  endfunction

  // Advance the tracked state by one accepted byte and queue what it owes.
  function automatic void huffman_step(logic [1:0] cmd, logic [7:0] b);
    step_results.delete();
    case (cmd)
      jhsd_pkg::CMD_TABLE:   table_byte(b);
      jhsd_pkg::CMD_DATA:    data_byte(b);
      jhsd_pkg::CMD_RESTART: begin
        reset_decoder_state();
      end
      default:     emit_result(jhsd_pkg::KIND_MISUSE, 8'h00, 5'd0);
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    awaited_results = {awaited_results, step_results};
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Leave valid high after the transfer: the next call either keeps it high with
  // a new byte or drops it for a gap, so valid gets one update per time step.
  task automatic send_item(logic [1:0] cmd, logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    byte_value_i <= b;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    huffman_step(cmd, b);
    transfers_in++;
  endtask

  // Drop valid and hold until every owed result is out, then let silent jobs finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_counts(input int counts[NUM_LEN]);
    foreach (counts[i]) send_item(jhsd_pkg::CMD_TABLE, 8'(counts[i]));
  endtask

  // Send as many symbol bytes as the clamped counts call for.
  task automatic send_symbols();
    int n;
    n = sym_total;
    repeat (n) send_item(jhsd_pkg::CMD_TABLE, 8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------
  always @(rx_hold_ev) begin
    rx_held <= 1'b1;
    repeat (rx_hold_len) @(posedge clk);
    rx_held <= 1'b0;
  end

  always @(posedge clk) begin
    out_ready_i <= !rx_held && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d (0x%0h), got %0d (0x%0h)", name, want, want, got, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid_o && out_ready_i) begin
      results_out++;
      kind_hits[kind_o]++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d value 0x%0h code_length %0d last %0b",
               kind_o, value_o, code_length_o, last_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("value", want.value, value_o);
        check_field("code_length", want.code_len, code_length_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles,
               awaited_results.size());
      $display("jpeg_huffman_symbol_decoder_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Data with no table, the unused command code, and a restart with nothing to undo.
  task automatic test_before_table();
    send_item(jhsd_pkg::CMD_DATA, 8'h00);
    send_item(CMD_UNKNOWN, 8'hFF);
    send_item(jhsd_pkg::CMD_RESTART, 8'hFF);
    send_item(jhsd_pkg::CMD_DATA, 8'hFF);
  endtask

  // All counts zero: ready at the last count, every code runs out at 16 bits,
  // and a table byte after completion is refused.
  task automatic test_empty_table();
    send_counts('{default: 0});
    send_item(jhsd_pkg::CMD_DATA, 8'h00);
    send_item(jhsd_pkg::CMD_DATA, 8'hA5);
    send_item(jhsd_pkg::CMD_DATA, 8'h7E);
    send_item(jhsd_pkg::CMD_TABLE, 8'h01);
  endtask

  // Counts beyond the code space, then beyond the symbol store.
  task automatic test_clamped_counts();
    send_item(jhsd_pkg::CMD_RESTART, 8'h00);
    // three one-bit codes cannot exist: clamp to two, then no room at length 2
    send_counts('{3, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255});
    send_symbols();
    // eight one-bit codes in one byte: the most results one byte can cause
    send_item(jhsd_pkg::CMD_DATA, 8'hA5);
    send_item(jhsd_pkg::CMD_DATA, 8'h00);
    send_item(jhsd_pkg::CMD_RESTART, 8'h00);
    // 255 + 255 overflows the store; clamp at length 9 and again at length 10
    repeat (7) send_item(jhsd_pkg::CMD_TABLE, 8'h00);
    send_item(jhsd_pkg::CMD_TABLE, 8'd255);
    send_item(jhsd_pkg::CMD_TABLE, 8'd255);
    send_item(jhsd_pkg::CMD_TABLE, 8'd7);
    send_item(jhsd_pkg::CMD_RESTART, 8'h00);
  endtask

  // One code per length and two at 16 bits, so a run of ones reaches the longest code.
  task automatic test_long_codes();
    send_item(jhsd_pkg::CMD_RESTART, 8'h00);
    send_counts('{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 2});
    send_symbols();
    send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_FF);
    send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_00);
    send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_FF);
    send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_00);
    send_item(jhsd_pkg::CMD_DATA, 8'h00);
    send_item(jhsd_pkg::CMD_DATA, 8'hBF);
  endtask

  // Fill bytes before a restart marker, a restart marker mid-code, then a halt.
  task automatic test_markers();
    send_item(jhsd_pkg::CMD_DATA, 8'hFE);
    send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_FF);
    send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_FF);
    send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::RST_FIRST);
    send_item(jhsd_pkg::CMD_DATA, 8'h7F);
    send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_FF);
    send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::RST_LAST);
    send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_FF);
    send_item(jhsd_pkg::CMD_DATA, 8'hC4);
    send_item(jhsd_pkg::CMD_DATA, 8'h00);   // dropped while halted
    send_item(jhsd_pkg::CMD_RESTART, 8'h00);
    send_item(jhsd_pkg::CMD_DATA, 8'h00);   // refused: no table after the restart
    settle();
  endtask

  // Stop taking results for a long stretch while bytes keep coming, so the job
  // queue fills and the input stalls. A zero byte makes a burst of short codes.
  task automatic test_backpressure();
    int saved_idle;
    settle();
    rx_hold_len = HOLD_CYCLES;
    -> rx_hold_ev;
    saved_idle  = tx_idle_pct;
    tx_idle_pct = 0;
    send_item(jhsd_pkg::CMD_DATA, 8'h00);
    repeat (9) send_item(jhsd_pkg::CMD_DATA, 8'($urandom_range(254)));
    tx_idle_pct = saved_idle;
    settle();
  endtask

  // Mostly plain data over the loaded table, mixed with stuffing, restart markers
  // and misuse.
  task automatic test_random_traffic(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_item(jhsd_pkg::CMD_DATA, 8'($urandom_range(254)));
      end else if (pick < 75) begin
        send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_FF);
        send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_00);
      end else if (pick < 87) begin
        send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_FF);
        if ($urandom_range(1) == 1) send_item(jhsd_pkg::CMD_DATA, jhsd_pkg::BYTE_FF);
        send_item(jhsd_pkg::CMD_DATA, 8'(jhsd_pkg::RST_FIRST + $urandom_range(7)));
      end else if (pick < 94) begin
        send_item(CMD_UNKNOWN, 8'($urandom_range(255)));
      end else begin
        send_item(jhsd_pkg::CMD_TABLE, 8'($urandom_range(255)));
      end
    end
    settle();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid_i   = 1'b0;
    command_i    = jhsd_pkg::CMD_TABLE;
    byte_value_i = 8'h00;
    out_ready_i  = 1'b0;
    tx_idle_pct  = 37;
    rx_idle_pct  = 63;
    reset_decoder_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_table();
    test_empty_table();
    test_clamped_counts();
    test_long_codes();

    tx_idle_pct = 63;
    rx_idle_pct = 37;
    test_backpressure();
    test_random_traffic(6);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(6);
    test_markers();

    $display("%0d bytes in, %0d results out: %0d symbols, %0d bad codes, %0d table ready",
             transfers_in, results_out, kind_hits[jhsd_pkg::KIND_SYMBOL],
             kind_hits[jhsd_pkg::KIND_BAD], kind_hits[jhsd_pkg::KIND_READY]);
    $display("%0d restart markers, %0d halts, %0d misuse reports, %0d mismatches",
             kind_hits[jhsd_pkg::KIND_RST], kind_hits[jhsd_pkg::KIND_HALT],
             kind_hits[jhsd_pkg::KIND_MISUSE], mismatches);
    if (mismatches == 0) begin
      $display("jpeg_huffman_symbol_decoder_tb: PASS");
    end else begin
      $display("jpeg_huffman_symbol_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/jhsd_pkg.sv
sv/jhsd_ram.sv
sv/jhsd_queue.sv
sv/jhsd_front.sv
sv/jhsd_back.sv
sv/jpeg_huffman_symbol_decoder.sv
sv/jhsd_checker.sv
dv/jpeg_huffman_symbol_decoder_tb.sv
